### rtl/scfr_pkg.sv
// shared widths, register indexes and lookup structs of the serial frame receiver
package scfr_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 4;
	localparam int PAYLOAD_W = 64;
	localparam int EIDX_W    = 2;
	localparam int ENTRY_W   = 12;
	localparam int COUNT_W   = 3;
	localparam int REG_IDX_W = 3;
	localparam int SUM_W     = 16;
	localparam int LANES     = PAYLOAD_W / BYTE_W;
	localparam int POS_W     = $clog2(LANES);
	// entries a register can address
	localparam int REG_ENTRIES = 4;
	localparam int MAX_LEN     = 8;

	localparam logic [BYTE_W-1:0] PREAMBLE = 8'hAA;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_ZERO  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_LAST  = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
		logic [EIDX_W-1:0] sel;
	} lookup_req_t;

	typedef struct packed {
		logic              id_hit;
		logic [EIDX_W-1:0] id_index;
		logic              len_ok;
	} lookup_resp_t;

endpackage

### rtl/scfr_if.sv
// valid/ready channels for received bytes and accepted frames
interface scfr_byte_if;
	logic                         valid;
	logic                         ready;
	logic [scfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface scfr_frame_if;
	logic                            valid;
	logic                            ready;
	logic [scfr_pkg::BYTE_W-1:0]    frame_id;
	logic [scfr_pkg::LEN_W-1:0]     frame_length;
	logic [scfr_pkg::PAYLOAD_W-1:0] frame_payload;
	logic [scfr_pkg::EIDX_W-1:0]    entry_index;

	modport source (output valid, output frame_id, output frame_length,
		output frame_payload, output entry_index, input ready);
	modport sink (input valid, input frame_id, input frame_length,
		input frame_payload, input entry_index, output ready);
endinterface

### rtl/scfr_table.sv
// identifier table registers with first-match lookup and length check
module scfr_table #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [scfr_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [scfr_pkg::ENTRY_W-1:0]        wr_data,
	input  scfr_pkg::lookup_req_t               req,
	output scfr_pkg::lookup_resp_t              resp
);
	import scfr_pkg::*;

	logic [COUNT_W-1:0]   count_q;
	logic [ENTRY_W-1:0]   entry_q [TABLE_ENTRIES];
	logic [REG_IDX_W-1:0] wr_entry;
	logic [LEN_W-1:0]     want_len;

	assign wr_entry = wr_index - REG_ENTRY_ZERO;

	// register writes, entries beyond the table are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				entry_q[k] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_ENTRY_COUNT) begin
				count_q <= wr_data[COUNT_W-1:0];
			end
			if (wr_index >= REG_ENTRY_ZERO && wr_index <= REG_ENTRY_LAST) begin
				for (int k = 0; k < TABLE_ENTRIES; k++) begin
					if (REG_IDX_W'(k) == wr_entry) begin
						entry_q[k] <= wr_data;
					end
				end
			end
		end
	end

	always_comb begin
		// identifier match, lowest enabled entry wins
		resp.id_hit   = 1'b0;
		resp.id_index = '0;
		for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
			if (COUNT_W'(k) < count_q && entry_q[k][BYTE_W-1:0] == req.rx_byte) begin
				resp.id_hit   = 1'b1;
				resp.id_index = EIDX_W'(k);
			end
		end
		// expected length of the matched entry
		want_len = '0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if (k < REG_ENTRIES && EIDX_W'(k) == req.sel) begin
				want_len = entry_q[k][ENTRY_W-1:BYTE_W];
			end
		end
		resp.len_ok = (want_len <= LEN_W'(MAX_LEN))
			&& (req.rx_byte == {{(BYTE_W-LEN_W){1'b0}}, want_len});
	end

endmodule

### rtl/scfr_parse.sv
// input register, frame state machine and result register
module scfr_parse (
	input  logic                   clk,
	input  logic                   arst_n,
	scfr_byte_if.sink              rx,
	scfr_frame_if.source           frame,
	output scfr_pkg::lookup_req_t  req,
	input  scfr_pkg::lookup_resp_t resp
);
	import scfr_pkg::*;

	localparam logic [2:0] PH_SEARCH = 3'd0;
	localparam logic [2:0] PH_ID     = 3'd1;
	localparam logic [2:0] PH_LEN    = 3'd2;
	localparam logic [2:0] PH_DATA   = 3'd3;
	localparam logic [2:0] PH_SUM_HI = 3'd4;
	localparam logic [2:0] PH_SUM_LO = 3'd5;

	logic                 valid_s1;
	logic [BYTE_W-1:0]    byte_s1;
	logic                 advance;

	logic [2:0]           phase_q, phase_d;
	logic [EIDX_W-1:0]    matched_q, matched_d;
	logic [LEN_W-1:0]     left_q, left_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [SUM_W-1:0]     sum_q, sum_d, sum_add;
	logic [BYTE_W-1:0]    chk_hi_q, chk_hi_d;
	logic [BYTE_W-1:0]    id_q, id_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [PAYLOAD_W-1:0] payload_q, payload_d;
	logic                 produce;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_id_q;
	logic [LEN_W-1:0]     out_len_q;
	logic [PAYLOAD_W-1:0] out_payload_q;
	logic [EIDX_W-1:0]    out_index_q;

	// handshake: the input stage moves on when the result register can take a word
	assign advance  = valid_s1 && (!out_valid_q || frame.ready);
	assign rx.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign req     = '{rx_byte: byte_s1, sel: matched_q};
	assign sum_add = sum_q + {{(SUM_W-BYTE_W){1'b0}}, byte_s1};

	// next frame state for the byte in the input register
	always_comb begin
		phase_d   = PH_SEARCH;
		matched_d = matched_q;
		left_d    = left_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		chk_hi_d  = chk_hi_q;
		id_d      = id_q;
		len_d     = len_q;
		payload_d = payload_q;
		produce   = 1'b0;
		case (phase_q)
			PH_ID: begin
				if (resp.id_hit) begin
					matched_d = resp.id_index;
					id_d      = byte_s1;
					sum_d     = sum_add;
					phase_d   = PH_LEN;
				end
			end
			PH_LEN: begin
				if (resp.len_ok) begin
					len_d   = byte_s1[LEN_W-1:0];
					left_d  = byte_s1[LEN_W-1:0];
					pos_d   = '0;
					sum_d   = sum_add;
					phase_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (left_q != '0) begin
					for (int k = 0; k < LANES; k++) begin
						if (POS_W'(k) == pos_q) begin
							payload_d[k*BYTE_W +: BYTE_W] =
								payload_q[k*BYTE_W +: BYTE_W] | byte_s1;
						end
					end
					sum_d   = sum_add;
					pos_d   = pos_q + POS_W'(1);
					left_d  = left_q - LEN_W'(1);
					phase_d = (left_q == LEN_W'(1)) ? PH_SUM_HI : PH_DATA;
				end
			end
			PH_SUM_HI: begin
				chk_hi_d = byte_s1;
				phase_d  = PH_SUM_LO;
			end
			PH_SUM_LO: begin
				produce = ({chk_hi_q, byte_s1} == sum_q);
			end
			default: begin
				// preamble search, also for the unused codes
				if (byte_s1 == PREAMBLE) begin
					left_d    = '0;
					pos_d     = '0;
					matched_d = '0;
					chk_hi_d  = '0;
					id_d      = '0;
					len_d     = '0;
					payload_d = '0;
					sum_d     = {{(SUM_W-BYTE_W){1'b0}}, byte_s1};
					phase_d   = PH_ID;
				end
			end
		endcase
	end

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_SEARCH;
			matched_q <= '0;
			left_q    <= '0;
			pos_q     <= '0;
			sum_q     <= '0;
			chk_hi_q  <= '0;
			id_q      <= '0;
			len_q     <= '0;
			payload_q <= '0;
		end else if (advance) begin
			phase_q   <= phase_d;
			matched_q <= matched_d;
			left_q    <= left_d;
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			chk_hi_q  <= chk_hi_d;
			id_q      <= id_d;
			len_q     <= len_d;
			payload_q <= payload_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_id_q      <= id_q;
			out_len_q     <= len_q;
			out_payload_q <= payload_q;
			out_index_q   <= matched_q;
		end
	end

	assign frame.valid         = out_valid_q;
	assign frame.frame_id      = out_id_q;
	assign frame.frame_length  = out_len_q;
	assign frame.frame_payload = out_payload_q;
	assign frame.entry_index   = out_index_q;

endmodule

### rtl/serial_can_frame_receiver.sv
// serial frame receiver: byte in, checked frame with table entry out
// one byte word accepted per cycle, back to back, while the result side takes words
// a byte is held in the input register, the frame result shows the cycle after
// its last checksum byte is processed, valid from the result register
// the input register stalls only while an unread result blocks the result register
// reset clears the table, the entry count and the frame state to preamble search
module serial_can_frame_receiver #(
	parameter int TABLE_ENTRIES = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [scfr_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [scfr_pkg::ENTRY_W-1:0]   wr_data,
	scfr_byte_if.sink                      rx,
	scfr_frame_if.source                   frame
);
	import scfr_pkg::*;

	lookup_req_t  req;
	lookup_resp_t resp;

	// identifier table
	scfr_table #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req),
		.resp     (resp)
	);

	// frame parser
	scfr_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.frame  (frame),
		.req    (req),
		.resp   (resp)
	);

endmodule
